>>> hdl/snd_pkg.sv
// Shared types and constants for the 2D simplex noise generator.
package snd_pkg;

  localparam int WFRAC       = 24;
  localparam int TABLE_DEPTH = 256;
  localparam int PERM_AW     = $clog2(TABLE_DEPTH);
  localparam int OFS_W       = 32;
  localparam int CONTRIB_W   = 24;
  localparam int NOISE_W     = 16;

  localparam logic signed [29:0]      SKEW_Q30   = 30'sd393016785;
  localparam logic signed [28:0]      UNSKEW_Q30 = 29'sd226908346;
  localparam logic signed [OFS_W-1:0] UNSKEW_W   = 32'sd3545443;
  localparam logic signed [OFS_W-1:0] ONE_W      = 32'sd16777216;
  localparam logic signed [24:0]      DIAG_W     = 25'sd11863283;
  localparam logic [WFRAC-1:0]        HALF_W     = 24'd8388608;
  localparam logic signed [23:0]      SCALE_Q16  = 24'sd5334630;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    DIR_E, DIR_NE, DIR_N, DIR_NW, DIR_W, DIR_SW, DIR_S, DIR_SE
  } grad_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] dx;
    logic signed [OFS_W-1:0] dy;
    grad_t                   grad;
  } corner_t;

  typedef struct packed {
    logic               we;
    logic [PERM_AW-1:0] index;
    logic [7:0]         value;
  } perm_wr_t;

  typedef struct packed {
    logic valid;
    logic busy;
  } cell_stat_t;

endpackage

>>> hdl/snd_in_if.sv
// Input channel: command and payload with valid/ready handshake.
interface snd_in_if import snd_pkg::*; ();
  logic               valid;
  logic               ready;
  cmd_t               command;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic [7:0]         entry_index;
  logic [7:0]         entry_value;

  modport source (output valid, command, x_coord, y_coord, entry_index, entry_value,
                  input ready);
  modport sink   (input valid, command, x_coord, y_coord, entry_index, entry_value,
                  output ready);
endinterface

>>> hdl/snd_out_if.sv
// Result channel: noise value with valid/ready handshake.
interface snd_out_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

>>> hdl/simplex_noise_2d.sv
// 2D simplex noise generator. Accepts one sample per clock while the result channel does
// not stall, and the whole pipeline holds while it stalls. A table load is taken once no
// sample sits in the first four stages, since those samples still read the permutation
// table; a load therefore waits behind such samples and produces no result. The table
// holds the identity after reset and is kept in three copies so all five hash lookups
// of a sample proceed in the same cycle as lookups of its neighbors.
module simplex_noise_2d import snd_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  snd_in_if.sink   in_chan,
  snd_out_if.source out_chan
);

  localparam int SUMW = CONTRIB_W + 2;
  localparam int SCW  = SUMW + 24;
  localparam int RW   = SCW - 26;

  logic       adv;
  logic       in_xfer;
  logic       smp_valid;
  perm_wr_t   wr;
  cell_stat_t stat;
  corner_t    corners [3];

  logic signed [CONTRIB_W-1:0] contrib [3];
  logic [3:0]                  cv_r;
  logic                        sv_r;
  logic signed [SUMW-1:0]      sum_r;
  logic signed [SCW-1:0]       scaled;
  logic signed [RW-1:0]        rnd;
  logic signed [NOISE_W-1:0]   sat;
  logic                        out_valid_r;
  logic signed [NOISE_W-1:0]   out_noise_r;

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv && (in_chan.command == CMD_SAMPLE || !stat.busy);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign smp_valid     = in_xfer && in_chan.command == CMD_SAMPLE;
  assign wr.we         = in_xfer && in_chan.command == CMD_LOAD;
  assign wr.index      = in_chan.entry_index;
  assign wr.value      = in_chan.entry_value;

  snd_cell #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_cell (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .smp_valid (smp_valid),
    .x_coord   (in_chan.x_coord),
    .y_coord   (in_chan.y_coord),
    .wr        (wr),
    .stat      (stat),
    .corners   (corners)
  );

  for (genvar k = 0; k < 3; k++) begin : g_corner
    snd_corner u_corner (
      .clk     (clk),
      .en      (adv),
      .cin     (corners[k]),
      .contrib (contrib[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r        <= '0;
      sv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      cv_r        <= {cv_r[2:0], stat.valid};
      sv_r        <= cv_r[3];
      out_valid_r <= sv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= SUMW'(contrib[0]) + SUMW'(contrib[1]) + SUMW'(contrib[2]);
    end
  end

  // scale by 81.4, round half up to 14 fraction bits, saturate
  assign scaled = sum_r * SCALE_Q16 + SCW'(64'sd33554432);
  assign rnd    = signed'(scaled[SCW-1:26]);

  always_comb begin
    priority if (rnd > RW'(32767)) begin
      sat = 16'sh7FFF;
    end else if (rnd < -RW'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = rnd[NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_noise_r <= sat;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.noise_value = out_noise_r;

endmodule

>>> hdl/snd_perm.sv
// Permutation table copy: one write port, two registered read ports, identity after reset.
module snd_perm import snd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  perm_wr_t           wr,
  input  logic               rd_en,
  input  logic [PERM_AW-1:0] rd_addr_a,
  input  logic [PERM_AW-1:0] rd_addr_b,
  output logic [7:0]         rd_data_a,
  output logic [7:0]         rd_data_b
);

  logic [7:0]             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] written_r;
  logic [7:0]             q_a_r, q_b_r;
  logic                   hit_a_r, hit_b_r;
  logic [PERM_AW-1:0]     addr_a_r, addr_b_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.index] <= wr.value;
    end
    if (rd_en) begin
      q_a_r <= mem[rd_addr_a];
      q_b_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr.we) begin
      written_r[wr.index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hit_a_r  <= written_r[rd_addr_a];
      hit_b_r  <= written_r[rd_addr_b];
      addr_a_r <= rd_addr_a;
      addr_b_r <= rd_addr_b;
    end
  end

  // unwritten entries read as their own index
  assign rd_data_a = hit_a_r ? q_a_r : 8'(addr_a_r);
  assign rd_data_b = hit_b_r ? q_b_r : 8'(addr_b_r);

endmodule

>>> hdl/snd_cell.sv
// Front pipeline: skew, cell and triangle selection, corner offsets, gradient hashing.
module snd_cell import snd_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               smp_valid,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  perm_wr_t           wr,
  output cell_stat_t         stat,
  output corner_t            corners [3]
);

  localparam int F   = COORD_FRAC_BITS;
  localparam int SW  = 33;
  localparam int SPW = SW + 30;
  localparam int XSW = SW + 1;
  localparam int IW  = XSW - F;
  localparam int IJW = IW + 1;
  localparam int TPW = IJW + 29;
  localparam int TW  = TPW - 6;
  localparam int DW  = XSW;
  localparam int SHL = WFRAC - F;

  logic [5:0] v_r;

  // stage 1
  logic signed [31:0] x1_r, y1_r;
  // stage 2
  logic signed [SW-1:0]  sxy;
  logic signed [SPW-1:0] sprod;
  logic signed [31:0]    x2_r, y2_r;
  logic signed [SW-1:0]  s2_r;
  // stage 3
  logic signed [XSW-1:0] xs, ys;
  logic signed [IW-1:0]  i3_r, j3_r;
  logic [F-1:0]          fx3_r, fy3_r;
  logic signed [SW-1:0]  s3_r;
  logic [PERM_AW-1:0]    l1_addr_a, l1_addr_b;
  logic [7:0]            pa3, pb3;
  // stage 4
  logic signed [IJW-1:0] ij;
  logic signed [TPW-1:0] tprod;
  logic signed [TW-1:0]  tu4_r;
  logic signed [DW-1:0]  dxa4_r, dya4_r;
  logic [PERM_AW-1:0]    ii4_r;
  logic [7:0]            pa4_r, pb4_r;
  // stage 5
  logic signed [OFS_W-1:0] x0_5_r, y0_5_r;
  logic [PERM_AW-1:0]      ii5_r;
  logic [7:0]              pa5_r, pb5_r;
  // stage 6
  logic                    up;
  logic [PERM_AW-1:0]      si;
  logic [PERM_AW-1:0]      a0, a1, a2;
  logic signed [OFS_W-1:0] x1c, y1c, x2c, y2c;
  logic signed [OFS_W-1:0] dx6_r [3];
  logic signed [OFS_W-1:0] dy6_r [3];
  logic [7:0]              h0, h1, h2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], smp_valid};
    end
  end

  // a sample in stages 1..4 has table reads still ahead of it
  assign stat.busy  = |v_r[3:0];
  assign stat.valid = v_r[5];

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= x_coord;
      y1_r <= y_coord;
    end
  end

  assign sxy   = SW'(x1_r) + SW'(y1_r);
  assign sprod = sxy * SKEW_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r <= x1_r;
      y2_r <= y1_r;
      s2_r <= signed'(sprod[SPW-1:30]);
    end
  end

  assign xs        = XSW'(x2_r) + XSW'(s2_r);
  assign ys        = XSW'(y2_r) + XSW'(s2_r);
  assign l1_addr_a = ys[F+PERM_AW-1:F];
  assign l1_addr_b = l1_addr_a + 1'b1;

  always_ff @(posedge clk) begin
    if (en) begin
      i3_r  <= signed'(xs[XSW-1:F]);
      j3_r  <= signed'(ys[XSW-1:F]);
      fx3_r <= xs[F-1:0];
      fy3_r <= ys[F-1:0];
      s3_r  <= s2_r;
    end
  end

  snd_perm u_perm_l1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .rd_en     (en),
    .rd_addr_a (l1_addr_a),
    .rd_addr_b (l1_addr_b),
    .rd_data_a (pa3),
    .rd_data_b (pb3)
  );

  assign ij    = IJW'(i3_r) + IJW'(j3_r);
  assign tprod = ij * UNSKEW_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      tu4_r  <= signed'(tprod[TPW-1:6]);
      dxa4_r <= signed'(DW'(fx3_r)) - DW'(s3_r);
      dya4_r <= signed'(DW'(fy3_r)) - DW'(s3_r);
      ii4_r  <= i3_r[PERM_AW-1:0];
      pa4_r  <= pa3;
      pb4_r  <= pb3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_5_r <= OFS_W'((longint'(dxa4_r) <<< SHL) + longint'(tu4_r));
      y0_5_r <= OFS_W'((longint'(dya4_r) <<< SHL) + longint'(tu4_r));
      ii5_r  <= ii4_r;
      pa5_r  <= pa4_r;
      pb5_r  <= pb4_r;
    end
  end

  // lower triangle only when x0 > y0
  assign up  = !(x0_5_r > y0_5_r);
  assign si  = {{(PERM_AW-1){1'b0}}, ~up};
  assign a0  = ii5_r + pa5_r;
  assign a1  = ii5_r + si + (up ? pb5_r : pa5_r);
  assign a2  = ii5_r + 1'b1 + pb5_r;
  assign x1c = x0_5_r - (up ? '0 : ONE_W) + UNSKEW_W;
  assign y1c = y0_5_r - (up ? ONE_W : '0) + UNSKEW_W;
  assign x2c = x0_5_r - ONE_W + (UNSKEW_W <<< 1);
  assign y2c = y0_5_r - ONE_W + (UNSKEW_W <<< 1);

  always_ff @(posedge clk) begin
    if (en) begin
      dx6_r[0] <= x0_5_r;
      dy6_r[0] <= y0_5_r;
      dx6_r[1] <= x1c;
      dy6_r[1] <= y1c;
      dx6_r[2] <= x2c;
      dy6_r[2] <= y2c;
    end
  end

  snd_perm u_perm_l2a (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .rd_en     (en),
    .rd_addr_a (a0),
    .rd_addr_b (a1),
    .rd_data_a (h0),
    .rd_data_b (h1)
  );

  snd_perm u_perm_l2b (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .rd_en     (en),
    .rd_addr_a (a2),
    .rd_addr_b (a2),
    .rd_data_a (h2),
    .rd_data_b ()
  );

  assign corners[0] = '{dx: dx6_r[0], dy: dy6_r[0], grad: grad_t'(h0[2:0])};
  assign corners[1] = '{dx: dx6_r[1], dy: dy6_r[1], grad: grad_t'(h1[2:0])};
  assign corners[2] = '{dx: dx6_r[2], dy: dy6_r[2], grad: grad_t'(h2[2:0])};

endmodule

>>> hdl/snd_corner.sv
// Corner contribution pipeline: falloff^4 times gradient dot product.
module snd_corner import snd_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  corner_t                     cin,
  output logic signed [CONTRIB_W-1:0] contrib
);

  localparam int UW   = OFS_W + 2;
  localparam int D2W  = 2 * OFS_W + 1 - WFRAC;
  localparam int DPW  = UW + 25;
  localparam int DOTW = WFRAC + 2;
  localparam int CPW  = DOTW + WFRAC + 1;

  logic signed [2*OFS_W-1:0] dxx, dyy;
  logic signed [2*OFS_W:0]   d2sum;
  logic signed [UW-1:0]      ex, ey, u;
  logic [D2W-1:0]            d2_r;
  logic signed [UW-1:0]      u_r;
  logic                      diag_r;

  logic [WFRAC-1:0]          tt;
  logic [2*WFRAC-1:0]        tsq;
  logic signed [DPW-1:0]     dprod;
  logic [WFRAC-1:0]          t2_r;
  logic signed [DOTW-1:0]    dot8_r;
  logic                      tpos8_r;

  logic [2*WFRAC-1:0]        t2sq;
  logic [WFRAC-1:0]          t4_r;
  logic signed [DOTW-1:0]    dot9_r;
  logic                      tpos9_r;

  logic signed [CPW-1:0]     cprod;
  logic signed [CONTRIB_W-1:0] contrib_r;

  assign dxx   = cin.dx * cin.dx;
  assign dyy   = cin.dy * cin.dy;
  assign d2sum = (2*OFS_W+1)'(dxx) + (2*OFS_W+1)'(dyy);
  assign ex    = UW'(cin.dx);
  assign ey    = UW'(cin.dy);

  always_comb begin
    unique case (cin.grad)
      DIR_E:   u = ex;
      DIR_NE:  u = ex + ey;
      DIR_N:   u = ey;
      DIR_NW:  u = ey - ex;
      DIR_W:   u = -ex;
      DIR_SW:  u = -ex - ey;
      DIR_S:   u = -ey;
      DIR_SE:  u = ex - ey;
      default: u = ex;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r   <= d2sum[2*OFS_W:WFRAC];
      u_r    <= u;
      diag_r <= cin.grad[0];
    end
  end

  assign tt    = HALF_W - d2_r[WFRAC-1:0];
  assign tsq   = tt * tt;
  assign dprod = u_r * DIAG_W;

  always_ff @(posedge clk) begin
    if (en) begin
      tpos8_r <= d2_r < D2W'(HALF_W);
      t2_r    <= tsq[2*WFRAC-1:WFRAC];
      dot8_r  <= diag_r ? DOTW'(dprod >>> WFRAC) : DOTW'(u_r);
    end
  end

  assign t2sq = t2_r * t2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t4_r    <= t2sq[2*WFRAC-1:WFRAC];
      dot9_r  <= dot8_r;
      tpos9_r <= tpos8_r;
    end
  end

  assign cprod = signed'({1'b0, t4_r}) * dot9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      contrib_r <= tpos9_r ? signed'(cprod[WFRAC+CONTRIB_W-1:WFRAC]) : '0;
    end
  end

  assign contrib = contrib_r;

endmodule

>>> hdl/snd_checker.sv
// Port-level assertions for the simplex noise generator, bound to the top level.
module snd_checker import snd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input cmd_t        in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_noise_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_noise_value))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_sample_rate: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_command == CMD_SAMPLE && (!out_valid || out_ready) |-> in_ready)
    else $error("sample refused with free output");

  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid too soon after reset");

endmodule

bind simplex_noise_2d snd_checker u_snd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_command      (in_chan.command),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_noise_value (out_chan.noise_value)
);

>>> tb/sv/snd_tb_pkg.sv
// Testbench-side item type for the simplex noise generator.
package snd_tb_pkg;
  import snd_pkg::*;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [7:0]         entry_index;
    logic [7:0]         entry_value;
  } noise_cmd_t;

endpackage

>>> tb/sv/simplex_noise_2d_tb.sv
// Testbench for simplex_noise_2d: random and directed loads and samples against a noise predictor.
module simplex_noise_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import snd_pkg::*;
  import snd_tb_pkg::*;

  localparam int FRAC      = 16;
  localparam int N_RANDOM  = 1230;
  localparam int IDLE_LIM  = 5000;
  localparam int DRAIN_CYC = 40;

  logic clk;
  logic rst_n;

  snd_in_if  in_chan();
  snd_out_if out_chan();

  simplex_noise_2d #(.COORD_FRAC_BITS(FRAC)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  noise_cmd_t          pending_cmds[$];
  logic signed [15:0]  expected_noise[$];
  logic [7:0]          perm_copy[256];
  int                  err_count;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  hold_off;
  int                  idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint fshift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint corner_contrib(longint dx, longint dy, int g);
    longint t, t2, t4, dot, gx, gy;
    longint one, diag;
    one  = longint'(1) << 24;
    diag = 11863283;
    case (g)
      0: begin gx = one;   gy = 0;     end
      1: begin gx = diag;  gy = diag;  end
      2: begin gx = 0;     gy = one;   end
      3: begin gx = -diag; gy = diag;  end
      4: begin gx = -one;  gy = 0;     end
      5: begin gx = -diag; gy = -diag; end
      6: begin gx = 0;     gy = -one;  end
      default: begin gx = diag; gy = -diag; end
    endcase
    t = (longint'(1) << 23) - fshift(dx * dx + dy * dy, 24);
    if (t <= 0) return 0;
    t2  = fshift(t * t, 24);
    t4  = fshift(t2 * t2, 24);
    dot = fshift(gx * dx + gy * dy, 24);
    return fshift(t4 * dot, 24);
  endfunction

  function automatic logic signed [15:0] simplex_at(logic signed [31:0] xc,
                                                     logic signed [31:0] yc);
    longint x, y, s, i, j, t, x0, y0, x1, y1, x2, y2, sum, r, one, uw;
    int si, sj, ii, jj, g0, g1, g2;
    one = longint'(1) << 24;
    uw  = 3545443;
    x = xc;
    y = yc;
    s = fshift((x + y) * 393016785, 30);
    i = fshift(x + s, FRAC);
    j = fshift(y + s, FRAC);
    t = fshift((i + j) * 226908346, 6);
    x0 = (x - (i <<< FRAC)) * (longint'(1) << (24 - FRAC)) + t;
    y0 = (y - (j <<< FRAC)) * (longint'(1) << (24 - FRAC)) + t;
    si = (x0 > y0) ? 1 : 0;
    sj = 1 - si;
    x1 = x0 - si * one + uw;
    y1 = y0 - sj * one + uw;
    x2 = x0 - one + 2 * uw;
    y2 = y0 - one + 2 * uw;
    ii = int'(i & 255);
    jj = int'(j & 255);
    g0 = perm_copy[(ii + perm_copy[jj]) & 255] & 7;
    g1 = perm_copy[(ii + si + perm_copy[(jj + sj) & 255]) & 255] & 7;
    g2 = perm_copy[(ii + 1 + perm_copy[(jj + 1) & 255]) & 255] & 7;
    sum = corner_contrib(x0, y0, g0) + corner_contrib(x1, y1, g1)
        + corner_contrib(x2, y2, g2);
    r = fshift(sum * 5334630 + (longint'(1) << 25), 26);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic noise_cmd_t sample_cmd(logic signed [31:0] x, logic signed [31:0] y);
    noise_cmd_t c;
    c.command     = CMD_SAMPLE;
    c.x_coord     = x;
    c.y_coord     = y;
    c.entry_index = 8'($urandom);
    c.entry_value = 8'($urandom);
    return c;
  endfunction

  function automatic noise_cmd_t load_cmd(logic [7:0] idx, logic [7:0] val);
    noise_cmd_t c;
    c.command     = CMD_LOAD;
    c.x_coord     = $urandom;
    c.y_coord     = $urandom;
    c.entry_index = idx;
    c.entry_value = val;
    return c;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
      2: return 32'($signed($urandom_range(0, 32'h0001_ffff)) - 32'sh0001_0000);
      default: return {16'($signed($urandom_range(0, 400)) - 16'sd200), 16'($urandom)};
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        noise_cmd_t c;
        c = pending_cmds.pop_front();
        in_chan.valid       <= 1'b1;
        in_chan.command     <= c.command;
        in_chan.x_coord     <= c.x_coord;
        in_chan.y_coord     <= c.y_coord;
        in_chan.entry_index <= c.entry_index;
        in_chan.entry_value <= c.entry_value;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // input monitor: predict at acceptance
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) begin
      if (in_chan.command == CMD_LOAD)
        perm_copy[in_chan.entry_index] = in_chan.entry_value;
      else
        expected_noise.push_back(simplex_at(in_chan.x_coord, in_chan.y_coord));
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_noise.size() == 0) begin
        report_mismatch($sformatf("unexpected noise %0d", out_chan.noise_value));
      end else begin
        logic signed [15:0] want;
        want = expected_noise.pop_front();
        if (out_chan.noise_value !== want)
          report_mismatch($sformatf("noise got %0d want %0d", out_chan.noise_value, want));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_flushed();
    while (pending_cmds.size() > 0 || in_chan.valid) @(posedge clk);
  endtask

  task automatic add_random(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        pending_cmds.push_back(load_cmd(8'($urandom), 8'($urandom)));
      else
        pending_cmds.push_back(sample_cmd(rand_coord(), rand_coord()));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    err_count = 0;
    hold_off = 0;
    idle_cycles = 0;
    send_idle_pct = 9;
    recv_idle_pct = 65;
    in_chan.valid = 1'b0;
    in_chan.command = CMD_LOAD;
    in_chan.x_coord = '0;
    in_chan.y_coord = '0;
    in_chan.entry_index = '0;
    in_chan.entry_value = '0;
    out_chan.ready = 1'b0;
    for (int k = 0; k < 256; k++) perm_copy[k] = 8'(k);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, origin, diagonal tie, falloff cut, loads
    pending_cmds.push_back(sample_cmd(32'sh0000_0000, 32'sh0000_0000));
    pending_cmds.push_back(sample_cmd(32'sh7fff_ffff, 32'sh7fff_ffff));
    pending_cmds.push_back(sample_cmd(32'sh8000_0000, 32'sh8000_0000));
    pending_cmds.push_back(sample_cmd(32'sh7fff_ffff, 32'sh8000_0000));
    pending_cmds.push_back(sample_cmd(32'sh8000_0000, 32'sh7fff_ffff));
    pending_cmds.push_back(sample_cmd(32'sh0000_8000, 32'sh0000_8000));
    pending_cmds.push_back(sample_cmd(32'sh0000_c000, 32'sh0000_4000));
    pending_cmds.push_back(sample_cmd(32'sh0000_4000, 32'sh0000_c000));
    pending_cmds.push_back(sample_cmd(32'shffff_ffff, 32'sh0000_0001));
    pending_cmds.push_back(sample_cmd(32'sh0003_5a00, 32'shfffd_1234));
    pending_cmds.push_back(load_cmd(8'h00, 8'hff));
    pending_cmds.push_back(load_cmd(8'hff, 8'h00));
    pending_cmds.push_back(sample_cmd(32'sh0000_0000, 32'sh0000_0000));
    pending_cmds.push_back(load_cmd(8'h01, 8'h07));
    pending_cmds.push_back(sample_cmd(32'shffff_0000, 32'shffff_0000));
    pending_cmds.push_back(sample_cmd(32'sh00ff_8000, 32'sh0000_2000));
    for (int k = 0; k < 8; k++)
      pending_cmds.push_back(sample_cmd(32'(k) <<< 15, 32'(7 - k) <<< 14));

    // random: first phase with a long receiver hold-off
    add_random(N_RANDOM / 3);
    @(posedge clk);
    hold_off = 200;
    wait_flushed();

    send_idle_pct = 65;
    recv_idle_pct = 9;
    // reshuffle the table with a permutation then keep sampling
    for (int k = 0; k < 256; k++)
      pending_cmds.push_back(load_cmd(8'(k), 8'(k * 37 + 11)));
    add_random(N_RANDOM / 3);
    wait_flushed();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(N_RANDOM / 3);
    wait_flushed();

    while (expected_noise.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
